// ===== rtl/fsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsr_pkg: shared types, constants and fuel model table
// Fixed-point coefficients of the spread rate datapath and the per-model ROM.
// ----------------------------------------------------------------------------
package fsr_pkg;

  localparam int FSR_FUEL_MODELS = 13;
  localparam int FSR_ROM_ENTRIES = 13;

  localparam int FSR_DIV_NUM_W = 64;
  localparam int FSR_DIV_DEN_W = 27;
  localparam int FSR_DIV_QUO_W = 32;

  localparam logic [62:0] FSR_S_CAP    = 63'h4000_0000_0000_0000;
  localparam logic [16:0] FSR_ONE      = 17'd65536;
  localparam logic [15:0] FSR_WIND_K   = 16'd50394;
  localparam logic [26:0] FSR_Q_BASE   = 27'd16384000;
  localparam logic [10:0] FSR_Q_GAIN   = 11'd1116;

  // ceil(2^66 / 1000000): exact floor division by 1000000 for 46-bit inputs
  localparam logic [46:0] FSR_SLOPE_RCP = 47'd73786976294839;

  localparam logic [17:0] FSR_ETA_A = 18'd169738;
  localparam logic [18:0] FSR_ETA_B = 19'd334889;
  localparam logic [17:0] FSR_ETA_C = 18'd230687;

  localparam logic [12:0] FSR_EXP_C3 = 13'd5190;
  localparam logic [13:0] FSR_EXP_C2 = 14'd14752;
  localparam logic [15:0] FSR_EXP_C1 = 16'd45593;
  localparam logic signed [24:0] FSR_EXP_BIAS = 25'sd1048576;
  localparam logic [8:0] FSR_K_MAX = 9'd45;

  typedef struct packed {
    logic [14:0]        mx;
    logic [48:0]        pr;
    logic signed [22:0] kwl;
    logic [18:0]        bw;
    logic [17:0]        ks;
  } fsr_rom_t;

  function automatic fsr_rom_t fsr_rom(input logic [3:0] idx);
    fsr_rom_t r;
    case (idx)
      4'd1:    r = '{15'd9830,  49'd32647807,        -23'sd1965595, 19'd257836, 18'd83024};
      4'd2:    r = '{15'd16384, 49'd4250822,         -23'sd1963518, 19'd257836, 18'd146570};
      4'd3:    r = '{15'd13107, 49'd1592590,         -23'sd1411750, 19'd190596, 18'd128909};
      4'd4:    r = '{15'd13107, 49'd239614,          -23'sd1407490, 19'd190596, 18'd157379};
      4'd5:    r = '{15'd16384, 49'd531542,          -23'sd1412347, 19'd190596, 18'd125381};
      4'd6:    r = '{15'd26214, 49'd442692,          -23'sd1410499, 19'd190596, 18'd136683};
      4'd7:    r = '{15'd19661, 49'd451169500000000, -23'sd1967482, 19'd257836, 18'd49459};
      4'd8:    r = '{15'd16384, 49'd454937805,       -23'sd2127423, 19'd277107, 18'd70333};
      4'd9:    r = '{15'd16384, 49'd3047686,         -23'sd1614558, 19'd214995, 18'd78882};
      4'd10:   r = '{15'd9830,  49'd605907,          -23'sd1422452, 19'd190596, 18'd78129};
      4'd11:   r = '{15'd13107, 49'd2521596,         -23'sd1422249, 19'd190596, 18'd78863};
      4'd12:   r = '{15'd16384, 49'd7575044,         -23'sd1423881, 19'd190596, 18'd73073};
      default: r = '{15'd7864,  49'd1288195,         -23'sd1962987, 19'd257836, 18'd169628};
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/fsr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsr_div: pipelined restoring divider
// One quotient bit per stage; the quotient must fit in QUO_W bits.
// ----------------------------------------------------------------------------
module fsr_div
  import fsr_pkg::*;
#(
  parameter int NUM_W = FSR_DIV_NUM_W,
  parameter int DEN_W = FSR_DIV_DEN_W,
  parameter int QUO_W = FSR_DIV_QUO_W
) (
  input  logic             clk,
  input  logic             ce,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  logic [DEN_W-1:0] rem_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic [QUO_W-1:0] low_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];

  for (genvar gi = 0; gi < QUO_W; gi++) begin : g_st
    logic [DEN_W-1:0] rp;
    logic [DEN_W-1:0] dp;
    logic [QUO_W-1:0] lp;
    logic [QUO_W-1:0] qp;
    logic [DEN_W:0]   t;
    logic             ge;
    if (gi == 0) begin : g_first
      assign rp = DEN_W'(num >> QUO_W);
      assign dp = den;
      assign lp = num[QUO_W-1:0];
      assign qp = '0;
    end else begin : g_rest
      assign rp = rem_r[gi-1];
      assign dp = den_r[gi-1];
      assign lp = low_r[gi-1];
      assign qp = quo_r[gi-1];
    end
    assign t  = {rp, lp[QUO_W-1]};
    assign ge = t >= {1'b0, dp};
    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[gi] <= ge ? DEN_W'(t - {1'b0, dp}) : t[DEN_W-1:0];
        den_r[gi] <= dp;
        low_r[gi] <= lp << 1;
        quo_r[gi] <= {qp[QUO_W-2:0], ge};
      end
    end
  end

  assign quo = quo_r[QUO_W-1];

endmodule

// ===== rtl/fire_spread_rate_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fire_spread_rate_unit: surface fire spread rate, a grid cell per unstalled cycle
// Damping, wind and slope factors, heat-of-preignition division, saturation.
// ----------------------------------------------------------------------------
// Input stream s_t*: one transaction per cell (fuel model, slope, moisture,
// wind speed). Output stream m_t*: one transaction per cell, the spread rate
// in Q16.16 m/s on m_tdata and the saturation flag on m_tuser, in input order.
// The path from the accepting input edge to m_tvalid spans 68 register
// stages; throughput is one cell per cycle when the output does not stall.
// Depth is set by the 16-step moisture ratio divider, the 16-step log2
// squaring chain, the exp2 polynomial, the split product and the 32-step
// rate divider at the tail, all fully pipelined.
// Reset clears every stage valid bit; the pipe comes up empty and ready.
// When the receiver stalls with a result waiting, the whole pipe holds and
// s_tready drops; nothing is lost or repeated. Bubbles travel as invalid
// stages and are skipped at the output.
// ----------------------------------------------------------------------------
module fire_spread_rate_unit
  import fsr_pkg::*;
#(
  parameter int FUEL_MODELS = FSR_FUEL_MODELS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // fuel_model[3:0], slope[17:4], moisture[33:18],
                                 // wind_speed[49:34], zero pad[55:50]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // spread_rate[31:0]
  output logic        m_tuser    // saturated[0]
);

  localparam int LAT       = 68;
  localparam int LOG_STEPS = 16;
  localparam int PR_N      = 20;
  localparam int BW_N      = 17;
  localparam int KWL_N     = 18;
  localparam int ZERO_N    = 19;
  localparam int Q_N       = 32;
  localparam int WF_N      = 4;
  localparam int X_N       = 7;
  localparam int SAT_N     = 32;
  localparam int WS_N      = 25;

  logic [LAT-1:0] vld;
  logic           en;

  assign en       = !vld[LAT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // stage 1: capture
  logic [3:0]  id1;
  logic [13:0] slope1;
  logic [15:0] m1;
  logic [15:0] u1;

  always_ff @(posedge clk) begin
    if (en) begin
      id1    <= s_tdata[3:0];
      slope1 <= s_tdata[17:4];
      m1     <= s_tdata[33:18];
      u1     <= s_tdata[49:34];
    end
  end

  // stage 2: table lookup
  logic       in_range1;
  logic [3:0] sel1;
  fsr_rom_t   rom1;

  always_comb begin
    in_range1 = id1 != 4'd0 && {1'b0, id1} <= 5'(FUEL_MODELS)
                && {1'b0, id1} <= 5'(FSR_ROM_ENTRIES);
    sel1 = in_range1 ? id1 - 4'd1 : 4'd0;
    rom1 = fsr_rom(sel1);
  end

  logic [14:0]        mx2;
  logic [48:0]        pr2;
  logic signed [22:0] kwl2;
  logic [18:0]        bw2;
  logic [17:0]        ks2;
  logic               zero2;
  logic [15:0]        m2;
  logic [31:0]        v2;
  logic [27:0]        sq2;

  always_ff @(posedge clk) begin
    if (en) begin
      mx2   <= rom1.mx;
      pr2   <= rom1.pr;
      kwl2  <= rom1.kwl;
      bw2   <= rom1.bw;
      ks2   <= rom1.ks;
      zero2 <= m1 >= {1'b0, rom1.mx};
      m2    <= m1;
      v2    <= 32'(u1) * 32'(FSR_WIND_K) + 32'(FSR_ONE);
      sq2   <= 28'(slope1) * 28'(slope1);
    end
  end

  // damping ratio divider: stages 3..18
  logic [31:0] numa2;
  logic [15:0] r18;

  assign numa2 = zero2 ? '0 : {m2, 16'h0000};

  fsr_div #(
    .NUM_W(32),
    .DEN_W(15),
    .QUO_W(16)
  ) u_div_damp (
    .clk (clk),
    .ce  (en),
    .num (numa2),
    .den (mx2),
    .quo (r18)
  );

  // stage 3: slope product, heat term, log normalize
  logic [4:0]  lp_c;
  logic [30:0] lx_c;
  logic [45:0] wsp3;
  logic [26:0] q3;
  logic [30:0] lx3;
  logic [3:0]  lk3;

  always_comb begin
    lp_c = 5'd16;
    for (int i = 17; i < 32; i++) begin
      if (v2[i]) begin
        lp_c = 5'(i);
      end
    end
    if (lp_c == 5'd31) begin
      lx_c = v2[31:1];
    end else begin
      lx_c = 31'(v2 << (5'd30 - lp_c));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wsp3 <= 46'(ks2) * 46'(sq2);
      q3   <= FSR_Q_BASE + 27'(m2) * 27'(FSR_Q_GAIN);
      lx3  <= lx_c;
      lk3  <= 4'(lp_c - 5'd16);
    end
  end

  // slope factor by reciprocal multiply: stages 4..5, delay to stage 30
  logic [45:0] sll4;
  logic [46:0] slh4;
  logic [45:0] shl4;
  logic [46:0] shh4;
  logic [92:0] sp_c;
  logic [26:0] ws5;
  logic [26:0] ws_d [WS_N];
  logic [26:0] ws30;

  assign sp_c = 93'(sll4) + (93'(slh4) << 23) + (93'(shl4) << 23) + (93'(shh4) << 46);
  assign ws30 = ws_d[WS_N-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sll4    <= 46'(wsp3[22:0]) * 46'(FSR_SLOPE_RCP[22:0]);
      slh4    <= 47'(wsp3[22:0]) * 47'(FSR_SLOPE_RCP[46:23]);
      shl4    <= 46'(wsp3[45:23]) * 46'(FSR_SLOPE_RCP[22:0]);
      shh4    <= 47'(wsp3[45:23]) * 47'(FSR_SLOPE_RCP[46:23]);
      ws5     <= sp_c[92:66];
      ws_d[0] <= ws5;
      for (int i = 1; i < WS_N; i++) ws_d[i] <= ws_d[i-1];
    end
  end

  // log2 fraction by repeated squaring: stages 4..19
  logic [30:0] lx [LOG_STEPS];
  logic [15:0] lf [LOG_STEPS];
  logic [3:0]  lk [LOG_STEPS];

  for (genvar gi = 0; gi < LOG_STEPS; gi++) begin : g_log
    logic [30:0] xi;
    logic [15:0] fi;
    logic [3:0]  ki;
    logic [61:0] sq;
    logic [31:0] y;
    if (gi == 0) begin : g_first
      assign xi = lx3;
      assign fi = '0;
      assign ki = lk3;
    end else begin : g_rest
      assign xi = lx[gi-1];
      assign fi = lf[gi-1];
      assign ki = lk[gi-1];
    end
    assign sq = 62'(xi) * 62'(xi);
    assign y  = sq[61:30];
    always_ff @(posedge clk) begin
      if (en) begin
        lx[gi] <= y[31] ? y[31:1] : y[30:0];
        lf[gi] <= {fi[14:0], y[31]};
        lk[gi] <= ki;
      end
    end
  end

  // delay lines
  logic [48:0]        pr_d   [PR_N];
  logic [18:0]        bw_d   [BW_N];
  logic signed [22:0] kwl_d  [KWL_N];
  logic               zero_d [ZERO_N];
  logic [26:0]        q_d    [Q_N];
  logic [62:0]        wf_d   [WF_N];
  logic [49:0]        x_d    [X_N];
  logic               sat_d  [SAT_N];
  logic [62:0]        wf26;
  logic [49:0]        x24;
  logic               sat35;
  logic [62:0]        wf26_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pr_d[0]   <= pr2;
      bw_d[0]   <= bw2;
      kwl_d[0]  <= kwl2;
      zero_d[0] <= zero2;
      q_d[0]    <= q3;
      wf_d[0]   <= wf26_r;
      x_d[0]    <= x24;
      sat_d[0]  <= sat35;
      for (int i = 1; i < PR_N; i++) pr_d[i] <= pr_d[i-1];
      for (int i = 1; i < BW_N; i++) bw_d[i] <= bw_d[i-1];
      for (int i = 1; i < KWL_N; i++) kwl_d[i] <= kwl_d[i-1];
      for (int i = 1; i < ZERO_N; i++) zero_d[i] <= zero_d[i-1];
      for (int i = 1; i < Q_N; i++) q_d[i] <= q_d[i-1];
      for (int i = 1; i < WF_N; i++) wf_d[i] <= wf_d[i-1];
      for (int i = 1; i < X_N; i++) x_d[i] <= x_d[i-1];
      for (int i = 1; i < SAT_N; i++) sat_d[i] <= sat_d[i-1];
    end
  end

  // wind factor: stages 20..26
  logic [19:0]        lg19;
  logic [38:0]        wm20;
  logic signed [24:0] wl21;
  logic signed [24:0] e_c;
  logic               eneg22, eneg23, eneg24, eneg25;
  logic [8:0]         k22, k23, k24, k25;
  logic [15:0]        f22, f23, f24;
  logic [12:0]        t1_23;
  logic [14:0]        t2_24;
  logic [16:0]        t3_25;
  logic [16:0]        mant25;

  assign lg19   = {lk[LOG_STEPS-1], lf[LOG_STEPS-1]};
  assign e_c    = wl21 + FSR_EXP_BIAS;
  assign mant25 = FSR_ONE + t3_25;

  always_comb begin
    if (eneg25) begin
      wf26 = '0;
    end else if (k25 > FSR_K_MAX) begin
      wf26 = FSR_S_CAP;
    end else if (k25 >= 9'd16) begin
      wf26 = 63'(mant25) << (k25 - 9'd16);
    end else begin
      wf26 = 63'(mant25) >> (9'd16 - k25);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wm20   <= 39'(bw_d[BW_N-1]) * 39'(lg19);
      wl21   <= 25'(kwl_d[KWL_N-1]) + $signed({2'b00, wm20[38:16]});
      eneg22 <= e_c[24];
      k22    <= e_c[24:16];
      f22    <= e_c[15:0];
      t1_23  <= 13'((32'(FSR_EXP_C3) * 32'(f22)) >> 16);
      eneg23 <= eneg22;
      k23    <= k22;
      f23    <= f22;
      t2_24  <= 15'(((32'(FSR_EXP_C2) + 32'(t1_23)) * 32'(f23)) >> 16);
      eneg24 <= eneg23;
      k24    <= k23;
      f24    <= f23;
      t3_25  <= 17'(((33'(FSR_EXP_C1) + 33'(t2_24)) * 33'(f24)) >> 16);
      eneg25 <= eneg24;
      k25    <= k24;
      wf26_r <= wf26;
    end
  end

  // moisture damping and reaction term: stages 19..24
  logic [15:0] r19, r20;
  logic [15:0] r2_19, r2_20;
  logic [15:0] r3_20;
  logic [19:0] pos21;
  logic [18:0] neg21;
  logic [19:0] diff_c;
  logic [16:0] eta_c;
  logic [16:0] eta22;
  logic [49:0] xa23;
  logic [16:0] xb23;

  always_comb begin
    diff_c = pos21 - {1'b0, neg21};
    if (zero_d[ZERO_N-1] || {1'b0, neg21} >= pos21) begin
      eta_c = '0;
    end else if (diff_c > 20'(FSR_ONE)) begin
      eta_c = FSR_ONE;
    end else begin
      eta_c = diff_c[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r19   <= r18;
      r2_19 <= 16'((32'(r18) * 32'(r18)) >> 16);
      r20   <= r19;
      r2_20 <= r2_19;
      r3_20 <= 16'((32'(r2_19) * 32'(r19)) >> 16);
      pos21 <= 20'(FSR_ONE) + 20'((35'(FSR_ETA_B) * 35'(r2_20)) >> 16);
      neg21 <= 19'((34'(FSR_ETA_A) * 34'(r20)) >> 16)
             + 19'((34'(FSR_ETA_C) * 34'(r3_20)) >> 16);
      eta22 <= eta_c;
      xa23  <= 50'(pr_d[PR_N-1][48:16]) * 50'(eta22);
      xb23  <= 17'((33'(pr_d[PR_N-1][15:0]) * 33'(eta22)) >> 16);
      x24   <= xa23 + 50'(xb23);
    end
  end

  // combine and product: stages 31..35
  logic [63:0]  s_sum;
  logic [62:0]  s31;
  logic [24:0]  xl_c, xh_c;
  logic [56:0]  pp_ll, pp_hl;
  logic [55:0]  pp_lh, pp_hh;
  logic [82:0]  a33;
  logic [112:0] b33;
  logic [112:0] prod34;
  logic         sat_c;
  logic [63:0]  dnum35;

  assign s_sum = 64'(FSR_ONE) + 64'(wf_d[WF_N-1]) + 64'(ws30);
  assign xl_c  = x_d[X_N-1][24:0];
  assign xh_c  = x_d[X_N-1][49:25];
  assign sat_c = (|prod34[112:64]) || prod34[63:0] >= {5'b0, q_d[Q_N-2], 32'h0};

  always_ff @(posedge clk) begin
    if (en) begin
      s31    <= s_sum > 64'(FSR_S_CAP) ? FSR_S_CAP : s_sum[62:0];
      pp_ll  <= 57'(xl_c) * 57'(s31[31:0]);
      pp_lh  <= 56'(xl_c) * 56'(s31[62:32]);
      pp_hl  <= 57'(xh_c) * 57'(s31[31:0]);
      pp_hh  <= 56'(xh_c) * 56'(s31[62:32]);
      a33    <= 83'(pp_ll) + (83'(pp_hl) << 25);
      b33    <= (113'(pp_lh) << 32) + (113'(pp_hh) << 57);
      prod34 <= 113'(a33) + b33;
      sat35  <= sat_c;
      dnum35 <= sat_c ? '0 : prod34[63:0];
    end
  end

  // rate divider: stages 36..67
  logic [31:0] rate67;

  fsr_div #(
    .NUM_W(FSR_DIV_NUM_W),
    .DEN_W(FSR_DIV_DEN_W),
    .QUO_W(FSR_DIV_QUO_W)
  ) u_div_rate (
    .clk (clk),
    .ce  (en),
    .num (dnum35),
    .den (q_d[Q_N-1]),
    .quo (rate67)
  );

  // stage 68: output register
  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= sat_d[SAT_N-1] ? '1 : rate67;
      m_tuser <= sat_d[SAT_N-1];
    end
  end

  a_sat_ones: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 32'hFFFF_FFFF)
    else $error("saturated result is not all ones");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while output stalled");

  a_log_norm: assert property (@(posedge clk) disable iff (rst)
    vld[18] |-> lx[LOG_STEPS-1][30])
    else $error("log2 mantissa lost normalization");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for fire_spread_rate_unit
// Streams fuel cells through the unit with random gaps and stalls on both
// sides, predicts each spread rate in fixed point, and checks the results
// in order.
// ----------------------------------------------------------------------------
module tb;
  import fsr_pkg::*;

  typedef struct packed {
    logic [15:0] wind;
    logic [15:0] moist;
    logic [13:0] slope;
    logic [3:0]  fuel;
  } cell_t;

  typedef struct packed {
    logic [31:0] rate;
    logic        sat;
  } spread_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;

  cell_t   cell_q[$];
  spread_t rate_q[$];
  cell_t   cur_cell;
  int      in_gap;
  int      out_gap;
  int      hold_at;
  int      sent = 0;
  int      issued = 0;
  int      checked = 0;
  int      errors = 0;
  int      n_sat = 0;
  int      n_zero = 0;
  bit      stim_done = 1'b0;

  fire_spread_rate_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  function automatic longint unsigned damping(longint unsigned m, longint unsigned mx);
    longint unsigned r, r2, r3, pos, neg;
    if (mx == 0 || m >= mx) return 0;
    r = (m << 16) / mx;
    if (r > 65535) r = 65535;
    r2 = (r * r) >> 16;
    r3 = (r2 * r) >> 16;
    pos = 65536 + ((334889 * r2) >> 16);
    neg = ((169738 * r) >> 16) + ((230687 * r3) >> 16);
    if (neg >= pos) return 0;
    pos -= neg;
    return (pos > 65536) ? 65536 : pos;
  endfunction

  function automatic longint unsigned log2_fix(longint unsigned v);
    int unsigned     p;
    longint unsigned x, frac;
    p = 16;
    frac = 0;
    for (int i = 17; i < 32; i++)
      if (v[i]) p = i;
    x = (p <= 30) ? (v << (30 - p)) : (v >> (p - 30));
    for (int i = 0; i < 16; i++) begin
      x = (x * x) >> 30;
      frac = frac << 1;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        frac = frac | 1;
      end
    end
    return (longint'(p - 16) << 16) | frac;
  endfunction

  function automatic longint unsigned exp2_fix(longint signed wl);
    longint signed   e;
    longint unsigned f, k, t, mant;
    e = wl + (longint'(16) << 16);
    if (e < 0) return 0;
    k = e >> 16;
    if (k > 45) return 64'h4000_0000_0000_0000;
    f = e & 64'hFFFF;
    t = (5190 * f) >> 16;
    t = ((14752 + t) * f) >> 16;
    t = ((45593 + t) * f) >> 16;
    mant = 65536 + t;
    return (k >= 16) ? (mant << (k - 16)) : (mant >> (16 - k));
  endfunction

  function automatic spread_t spread_rate(cell_t c);
    fsr_rom_t        rom;
    longint unsigned eta, x, v, lg, wf, ws, s, q, prod, rate;
    longint signed   wl;
    spread_t         res;
    rom = fsr_rom((c.fuel >= 1 && c.fuel <= FSR_FUEL_MODELS && c.fuel <= FSR_ROM_ENTRIES)
                  ? c.fuel - 4'd1 : 4'd0);
    eta = damping(c.moist, rom.mx);
    x = (rom.pr >> 16) * eta + (((rom.pr & 64'hFFFF) * eta) >> 16);
    v = longint'(c.wind) * 50394 + 65536;
    lg = log2_fix(v);
    wl = longint'(rom.kwl) + longint'((longint'(rom.bw) * lg) >> 16);
    wf = exp2_fix(wl);
    ws = (longint'(rom.ks) * c.slope * c.slope) / 1000000;
    s = 65536 + wf + ws;
    if (s > 64'h4000_0000_0000_0000) s = 64'h4000_0000_0000_0000;
    q = 250 * 65536 + 1116 * longint'(c.moist);
    res = '0;
    if (x == 0) return res;
    if (s > 64'hFFFF_FFFF_FFFF_FFFF / x) return '{32'hFFFF_FFFF, 1'b1};
    prod = x * s;
    rate = prod / q;
    if (rate > 64'hFFFF_FFFF) return '{32'hFFFF_FFFF, 1'b1};
    res.rate = rate[31:0];
    return res;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 2);
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("timeout at %0t", $time);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    cell_t c;
    for (int id = 0; id < 16; id++)
      cell_q.push_back('{16'd1024, 16'd3000, 14'd200, id[3:0]});
    cell_q.push_back('{16'd0, 16'd0, 14'd0, 4'd1});
    cell_q.push_back('{16'hFFFF, 16'd0, 14'h3FFF, 4'd8});
    cell_q.push_back('{16'hFFFF, 16'hFFFF, 14'h3FFF, 4'd8});
    cell_q.push_back('{16'd512, 16'd7864, 14'd100, 4'd1});
    cell_q.push_back('{16'd512, 16'd7863, 14'd100, 4'd1});
    cell_q.push_back('{16'hFFFF, 16'd100, 14'd10000, 4'd7});
    cell_q.push_back('{16'd0, 16'd26213, 14'd0, 4'd6});
    cell_q.push_back('{16'd256, 16'd0, 14'h3FFF, 4'd4});
    hold_at = cell_q.size() + 600;
    for (int i = 0; i < 1300; i++) begin
      c.fuel  = 4'($urandom_range(0, 15));
      c.slope = ($urandom_range(0, 3) == 0) ? 14'($urandom_range(0, 16383))
                                            : 14'($urandom_range(0, 10000));
      c.moist = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                            : 16'($urandom_range(0, 27000));
      c.wind  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                            : 16'($urandom_range(0, 8000));
      cell_q.push_back(c);
    end
  end

  always @(negedge clk) begin
    int gap;
    gap = in_gap;
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
      in_gap <= 0;
      out_gap <= 0;
      issued <= 0;
    end else begin
      if (s_tvalid && issued == sent) gap = pick_gap();
      if (!s_tvalid || issued == sent) begin
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          in_gap <= gap - 1;
        end else if (sent == hold_at && rate_q.size() != 0) begin
          // hold until the pipe has drained
          s_tvalid <= 1'b0;
          in_gap <= 0;
        end else if (cell_q.size() != 0) begin
          cur_cell = cell_q.pop_front();
          s_tdata <= {6'b0, cur_cell};
          s_tvalid <= 1'b1;
          issued <= issued + 1;
          in_gap <= 0;
        end else begin
          s_tvalid <= 1'b0;
          in_gap <= 0;
          stim_done <= 1'b1;
        end
      end
      if (out_gap > 0) begin
        m_tready <= 1'b0;
        out_gap <= out_gap - 1;
      end else begin
        m_tready <= 1'b1;
        out_gap <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    spread_t exp_r;
    if (rst) begin
      sent <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        rate_q.push_back(spread_rate(cur_cell));
        sent <= sent + 1;
      end
      if (m_tvalid && m_tready) begin
        if (rate_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result rate=%h sat=%b", $time, m_tdata, m_tuser);
        end else begin
          exp_r = rate_q.pop_front();
          checked++;
          if (exp_r.sat) n_sat++;
          if (exp_r.rate == 0) n_zero++;
          if (m_tdata !== exp_r.rate) begin
            errors++;
            $display("%0t: spread_rate expected %h actual %h", $time, exp_r.rate, m_tdata);
          end
          if (m_tuser !== exp_r.sat) begin
            errors++;
            $display("%0t: saturated expected %b actual %b", $time, exp_r.sat, m_tuser);
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done && rate_q.size() == 0);
    repeat (100) @(posedge clk);
    $display("cells sent %0d, results checked %0d", sent, checked);
    $display("zero rates %0d, saturated rates %0d", n_zero, n_sat);
    if (errors == 0 && rate_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
